[design/wpm_pkg.sv]
// ----------------------------------------------------------------------------
// wpm_pkg: shared constants and types of the window peak/mean level meter
// Window lengths, field widths, register defaults, register indexes and the
// stage record that travels down the divider cell chain.
// ----------------------------------------------------------------------------
package wpm_pkg;

   localparam int PEAK_LEN   = 20;
   localparam int AVG_LEN    = 200;
   localparam int SAMPLE_W   = 12;
   localparam int GAIN_W     = 10;
   localparam int GAIN_FRAC  = 8;
   localparam int FS_W       = 12;
   localparam int LED_W      = 8;
   localparam int LEVEL_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // running sum of the long window
   localparam int SUM_W    = $clog2(AVG_LEN * ((1 << SAMPLE_W) - 1) + 1);
   // sum times gain, fraction dropped
   localparam int SCALED_W = SUM_W + GAIN_W - GAIN_FRAC;

   // divide by AVG_LEN through a reciprocal and one correction step
   localparam int RDIV_W = (SCALED_W > SUM_W) ? SCALED_W : SUM_W;
   localparam int RDIV_M = (1 << RDIV_W) / AVG_LEN;
   localparam int QUO_W  = RDIV_W - $clog2(AVG_LEN) + 1;
   localparam int REM_W  = $clog2(2 * AVG_LEN);

   // scaled mean times LED count
   localparam int Y_W = QUO_W + LED_W;

   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(333);
   localparam logic [FS_W-1:0]   FS_RESET   = FS_W'(600);
   localparam logic [LED_W-1:0]  LED_RESET  = LED_W'(60);
   localparam logic [LEVEL_W-1:0] BASE_RESET = '0;

   localparam logic [CSR_IDX_W-1:0] CSR_AVG_GAIN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_LED_COUNT  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEVEL = CSR_IDX_W'(3);

   typedef struct packed {
      logic                valid;
      logic                ovf;
      logic [FS_W-1:0]     rem;
      logic [LEVEL_W-1:0]  quo;
      logic [LEVEL_W-1:0]  low;
      logic [SAMPLE_W-1:0] peak;
      logic [SAMPLE_W-1:0] mean;
   } div_stage_type;

endpackage

[design/wpm_peak_cell.sv]
// ----------------------------------------------------------------------------
// wpm_peak_cell: one cell of the short-window peak chain
// Holds the largest of the newest k+1 samples; on a shift it takes the larger
// of the new sample and its left neighbor's old value.
// ----------------------------------------------------------------------------
module wpm_peak_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic [wpm_pkg::SAMPLE_W-1:0] sample,
   input  logic [wpm_pkg::SAMPLE_W-1:0] max_prev,
   output logic [wpm_pkg::SAMPLE_W-1:0] max_out
);
   import wpm_pkg::*;

   logic [SAMPLE_W-1:0] max_ff;
   logic [SAMPLE_W-1:0] max_in;

   assign max_in  = (sample > max_prev) ? sample : max_prev;
   assign max_out = max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (shift) begin
         max_ff <= max_in;
      end
   end

endmodule

[design/wpm_window.sv]
// ----------------------------------------------------------------------------
// wpm_window: short and long sample windows
// A chain of peak cells gives the short-window maximum; a shift line with a
// running sum gives the long-window total. Both outputs show the windows as
// they stand before the next shift.
// ----------------------------------------------------------------------------
module wpm_window (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         shift,
   input  logic [wpm_pkg::SAMPLE_W-1:0] sample,
   output logic [wpm_pkg::SAMPLE_W-1:0] peak,
   output logic [wpm_pkg::SUM_W-1:0]    sum
);
   import wpm_pkg::*;

   logic [SAMPLE_W-1:0] peak_chain [PEAK_LEN+1];
   logic [SAMPLE_W-1:0] line_ff [AVG_LEN];
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_in;

   assign peak_chain[0] = '0;

   for (genvar i = 0; i < PEAK_LEN; i++) begin : g_peak
      wpm_peak_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (shift),
         .sample   (sample),
         .max_prev (peak_chain[i]),
         .max_out  (peak_chain[i+1])
      );
   end

   assign peak = peak_chain[PEAK_LEN];

   // drop the oldest sample, add the new one
   assign sum_in = sum_ff - SUM_W'(line_ff[AVG_LEN-1]) + SUM_W'(sample);
   assign sum    = sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AVG_LEN; k++) begin
            line_ff[k] <= '0;
         end
         sum_ff <= '0;
      end else if (shift) begin
         for (int k = AVG_LEN - 1; k > 0; k--) begin
            line_ff[k] <= line_ff[k-1];
         end
         line_ff[0] <= sample;
         sum_ff     <= sum_in;
      end
   end

endmodule

[design/wpm_rdiv.sv]
// ----------------------------------------------------------------------------
// wpm_rdiv: two-stage divide by the long-window length
// Stage one multiplies by the truncated reciprocal, which lands on the
// quotient or one below it; stage two checks the remainder and corrects.
// ----------------------------------------------------------------------------
module wpm_rdiv (
   input  logic                       clock,
   input  logic                       en,
   input  logic [wpm_pkg::RDIV_W-1:0] v,
   output logic [wpm_pkg::QUO_W-1:0]  q
);
   import wpm_pkg::*;

   localparam logic [QUO_W-1:0] RECIP = QUO_W'(RDIV_M);
   localparam logic [QUO_W-1:0] DIVQ  = QUO_W'(AVG_LEN);
   localparam logic [REM_W-1:0] DIVR  = REM_W'(AVG_LEN);

   logic [RDIV_W+QUO_W-1:0] prod;
   logic [QUO_W-1:0]        q0_in;
   logic [QUO_W-1:0]        q0_ff;
   logic [REM_W-1:0]        vlow_in;
   logic [REM_W-1:0]        vlow_ff;
   logic [QUO_W-1:0]        q0_times;
   logic [REM_W-1:0]        rem;
   logic [QUO_W-1:0]        q_in;
   logic [QUO_W-1:0]        q_ff;

   assign prod    = (RDIV_W + QUO_W)'(v) * (RDIV_W + QUO_W)'(RECIP);
   assign q0_in   = prod[RDIV_W +: QUO_W];
   assign vlow_in = v[REM_W-1:0];

   // remainder stays below twice the divisor, so its low bits suffice
   assign q0_times = q0_ff * DIVQ;
   assign rem      = vlow_ff - q0_times[REM_W-1:0];
   assign q_in     = (rem >= DIVR) ? q0_ff + QUO_W'(1) : q0_ff;
   assign q        = q_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         q0_ff   <= q0_in;
         vlow_ff <= vlow_in;
         q_ff    <= q_in;
      end
   end

endmodule

[design/wpm_div_cell.sv]
// ----------------------------------------------------------------------------
// wpm_div_cell: one restoring-division step of the LED level divider
// Shifts the next dividend bit into the partial remainder, subtracts the full
// scale when it fits and appends the quotient bit.
// ----------------------------------------------------------------------------
module wpm_div_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic [wpm_pkg::FS_W-1:0] full_scale,
   input  wpm_pkg::div_stage_type   d_in,
   output wpm_pkg::div_stage_type   d_out
);
   import wpm_pkg::*;

   div_stage_type   d_ff;
   div_stage_type   d_in_next;
   logic [FS_W:0]   trial;
   logic            fits;

   assign trial = {d_in.rem, d_in.low[LEVEL_W-1]};
   assign fits  = trial >= {1'b0, full_scale};

   always_comb begin
      d_in_next     = d_in;
      d_in_next.rem = fits ? FS_W'(trial - {1'b0, full_scale}) : FS_W'(trial);
      d_in_next.quo = {d_in.quo[LEVEL_W-2:0], fits};
      d_in_next.low = {d_in.low[LEVEL_W-2:0], 1'b0};
   end

   assign d_out = d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (en) begin
         d_ff <= d_in_next;
      end
   end

endmodule

[design/window_peak_mean_level_meter_top.sv]
// ----------------------------------------------------------------------------
// window_peak_mean_level_meter_top: sliding-window peak, mean and LED level
// Pipeline: the two reciprocal-divide stages and the 8-cell level divider chain
// lie among the registers between the accepting edge and rsp_valid.
// Throughput: one item per cycle; the pipeline holds only while a result item
// waits with rsp_stall high.
// Reset: windows and running sum clear, registers return to their defaults.
// ----------------------------------------------------------------------------
module window_peak_mean_level_meter_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [wpm_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [wpm_pkg::SAMPLE_W-1:0]   rsp_window_peak,
   output logic [wpm_pkg::SAMPLE_W-1:0]   rsp_window_mean,
   output logic [wpm_pkg::LEVEL_W-1:0]    rsp_mean_led_level,
   input  logic                           csr_we,
   input  logic [wpm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wpm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wpm_pkg::*;

   logic                pipe_en;
   logic                accept;

   logic [GAIN_W-1:0]   avg_gain_ff;
   logic [FS_W-1:0]     full_scale_ff;
   logic [LED_W-1:0]    led_count_ff;
   logic [LEVEL_W-1:0]  base_level_ff;

   logic [SAMPLE_W-1:0] win_peak;
   logic [SUM_W-1:0]    win_sum;

   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_peak_ff;
   logic [SUM_W-1:0]    s1_sum_ff;

   logic [SUM_W+GAIN_W-1:0] s1_prod;
   logic [SCALED_W-1:0] s2_scaled_in;
   logic                s2_valid_ff;
   logic [SAMPLE_W-1:0] s2_peak_ff;
   logic [SCALED_W-1:0] s2_scaled_ff;

   logic                s3_valid_ff;
   logic [SAMPLE_W-1:0] s3_peak_ff;

   logic [QUO_W-1:0]    mean_q;
   logic [QUO_W-1:0]    x_q;

   logic                s4_valid_ff;
   logic [SAMPLE_W-1:0] s4_peak_ff;
   logic [SAMPLE_W-1:0] s4_mean_ff;

   logic [Y_W-1:0]      s5_y_in;
   logic                s5_valid_ff;
   logic [SAMPLE_W-1:0] s5_peak_ff;
   logic [SAMPLE_W-1:0] s5_mean_ff;
   logic [Y_W-1:0]      s5_y_ff;

   logic [Y_W-LEVEL_W-1:0] y_high;
   logic                div_ovf;
   div_stage_type       div_head_in;
   div_stage_type       div_head_ff;
   div_stage_type       div_chain [LEVEL_W+1];
   div_stage_type       div_tail;

   logic [LEVEL_W:0]    level_sum;
   logic [LEVEL_W-1:0]  level_in;

   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_peak_ff;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;

   // whole pipeline advances together unless the output is held
   assign pipe_en   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !pipe_en;
   assign accept    = req_valid && pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_gain_ff   <= GAIN_RESET;
         full_scale_ff <= FS_RESET;
         led_count_ff  <= LED_RESET;
         base_level_ff <= BASE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AVG_GAIN:   avg_gain_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_FULL_SCALE: full_scale_ff <= csr_wdata[FS_W-1:0];
            CSR_LED_COUNT:  led_count_ff  <= csr_wdata[LED_W-1:0];
            CSR_BASE_LEVEL: base_level_ff <= csr_wdata[LEVEL_W-1:0];
         endcase
      end
   end

   wpm_window u_window (
      .clock  (clock),
      .reset  (reset),
      .shift  (accept),
      .sample (req_sample),
      .peak   (win_peak),
      .sum    (win_sum)
   );

   // stage 1: capture the windows as they stood before the item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   assign s1_prod      = (SUM_W + GAIN_W)'(s1_sum_ff) * (SUM_W + GAIN_W)'(avg_gain_ff);
   assign s2_scaled_in = s1_prod[SUM_W+GAIN_W-1:GAIN_FRAC];
   assign s5_y_in      = Y_W'(x_q) * Y_W'(led_count_ff);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_peak_ff   <= win_peak;
         s1_sum_ff    <= win_sum;
         s2_peak_ff   <= s1_peak_ff;
         s2_scaled_ff <= s2_scaled_in;
         s3_peak_ff   <= s2_peak_ff;
         s4_peak_ff   <= s3_peak_ff;
         s4_mean_ff   <= mean_q[SAMPLE_W-1:0];
         s5_peak_ff   <= s4_peak_ff;
         s5_mean_ff   <= s4_mean_ff;
         s5_y_ff      <= s5_y_in;
      end
   end

   wpm_rdiv u_mean_div (
      .clock (clock),
      .en    (pipe_en),
      .v     (RDIV_W'(s1_sum_ff)),
      .q     (mean_q)
   );

   wpm_rdiv u_scale_div (
      .clock (clock),
      .en    (pipe_en),
      .v     (RDIV_W'(s2_scaled_ff)),
      .q     (x_q)
   );

   // quotient of 256 or more saturates; otherwise the high part is the
   // starting remainder and the low byte feeds the divider cells
   assign y_high  = s5_y_ff[Y_W-1:LEVEL_W];
   assign div_ovf = y_high >= (Y_W - LEVEL_W)'(full_scale_ff);

   always_comb begin
      div_head_in       = '0;
      div_head_in.valid = s5_valid_ff;
      div_head_in.ovf   = div_ovf;
      div_head_in.rem   = div_ovf ? '0 : y_high[FS_W-1:0];
      div_head_in.low   = s5_y_ff[LEVEL_W-1:0];
      div_head_in.peak  = s5_peak_ff;
      div_head_in.mean  = s5_mean_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_head_ff <= '0;
      end else if (pipe_en) begin
         div_head_ff <= div_head_in;
      end
   end

   assign div_chain[0] = div_head_ff;

   for (genvar i = 0; i < LEVEL_W; i++) begin : g_div
      wpm_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (pipe_en),
         .full_scale (full_scale_ff),
         .d_in       (div_chain[i]),
         .d_out      (div_chain[i+1])
      );
   end

   assign div_tail  = div_chain[LEVEL_W];
   assign level_sum = {1'b0, div_tail.quo} + {1'b0, base_level_ff};
   assign level_in  = (div_tail.ovf || level_sum[LEVEL_W]) ? '1 : level_sum[LEVEL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= div_tail.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_peak_ff  <= div_tail.peak;
         rsp_mean_ff  <= div_tail.mean;
         rsp_level_ff <= level_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_peak    = rsp_peak_ff;
   assign rsp_window_mean    = rsp_mean_ff;
   assign rsp_mean_led_level = rsp_level_ff;

endmodule

[design/wpm_checker.sv]
// ----------------------------------------------------------------------------
// wpm_checker: port-level checks for the level meter
// Watches the item handshakes on the top-level ports.
// ----------------------------------------------------------------------------
module wpm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [wpm_pkg::SAMPLE_W-1:0]   req_sample,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [wpm_pkg::SAMPLE_W-1:0]   rsp_window_peak,
   input logic [wpm_pkg::SAMPLE_W-1:0]   rsp_window_mean,
   input logic [wpm_pkg::LEVEL_W-1:0]    rsp_mean_led_level
);
   import wpm_pkg::*;

   // a held result item keeps its valid and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_window_peak) &&
         $stable(rsp_window_mean) && $stable(rsp_mean_led_level))
      else $error("result item changed while stalled");

   // a stalled input item keeps its valid and its sample
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_sample))
      else $error("input item changed while stalled");

   // input stalls only when a result is waiting on a stalled output
   a_req_stall_cause: assert property (@(posedge clock)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result item");

   // no result item right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // an empty output never stalls the input
   a_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with an empty output");

endmodule

bind window_peak_mean_level_meter_top wpm_checker u_wpm_checker (.*);

[bench/window_peak_mean_level_meter_top_tb.sv]
// ----------------------------------------------------------------------------
// window_peak_mean_level_meter_top_tb: self-checking bench for the level meter
// Drives samples with random gaps, predicts the short-window peak,
// the long-window mean and the LED level of every item, and compares each
// result against the oldest prediction while both sides stall at random.
// ----------------------------------------------------------------------------
module window_peak_mean_level_meter_top_tb;
   import wpm_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 24;

   typedef struct packed {
      logic [SAMPLE_W-1:0] peak;
      logic [SAMPLE_W-1:0] mean;
      logic [LEVEL_W-1:0]  level;
   } meter_reading_type;

   typedef enum int {RUN_NOISE, RUN_LOUD, RUN_QUIET, RUN_RAMP} run_kind_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_sample;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [SAMPLE_W-1:0]   rsp_window_peak;
   logic [SAMPLE_W-1:0]   rsp_window_mean;
   logic [LEVEL_W-1:0]    rsp_mean_led_level;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state and register copies
   logic [SAMPLE_W-1:0] short_win [PEAK_LEN];
   logic [SAMPLE_W-1:0] long_win [AVG_LEN];
   logic [SUM_W-1:0]    long_sum;
   int                  short_pos;
   int                  long_pos;
   logic [GAIN_W-1:0]   cfg_gain;
   logic [FS_W-1:0]     cfg_full_scale;
   logic [LED_W-1:0]    cfg_leds;
   logic [LEVEL_W-1:0]  cfg_base;

   meter_reading_type pending_readings [$];
   int                error_count;
   int                cycle_count;

   bit tx_idle;
   bit rx_idle;
   bit rsp_taken;
   int rx_hold;
   int rx_gap;

   run_kind_type        run_kind;
   int                  run_left;
   logic [SAMPLE_W-1:0] ramp_val;

   window_peak_mean_level_meter_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_window_peak    (rsp_window_peak),
      .rsp_window_mean    (rsp_window_mean),
      .rsp_mean_led_level (rsp_mean_led_level),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("window_peak_mean_level_meter_top_tb: errors");
         $finish;
      end
   end

   function automatic void meter_clear();
      foreach (short_win[i]) short_win[i] = '0;
      foreach (long_win[i]) long_win[i] = '0;
      long_sum       = '0;
      short_pos      = 0;
      long_pos       = 0;
      cfg_gain       = GAIN_RESET;
      cfg_full_scale = FS_RESET;
      cfg_leds       = LED_RESET;
      cfg_base       = BASE_RESET;
   endfunction

   // results come from the windows as they stood before the sample enters
   function automatic meter_reading_type meter_predict(input logic [SAMPLE_W-1:0] s);
      meter_reading_type   r;
      logic [SAMPLE_W-1:0] top;
      longint unsigned     sum64, scaled, lvl;
      top   = '0;
      foreach (short_win[i])
         if (short_win[i] > top) top = short_win[i];
      sum64  = long_sum;
      scaled = (sum64 * 64'(cfg_gain)) / 64'(256 * AVG_LEN);
      if (cfg_full_scale == '0)
         lvl = 255;
      else
         lvl = scaled * 64'(cfg_leds) / 64'(cfg_full_scale) + 64'(cfg_base);
      if (lvl > 255) lvl = 255;
      r.peak  = top;
      r.mean  = SAMPLE_W'(sum64 / 64'(AVG_LEN));
      r.level = LEVEL_W'(lvl);
      short_win[short_pos] = s;
      short_pos = (short_pos + 1) % PEAK_LEN;
      long_sum = long_sum - long_win[long_pos] + s;
      long_win[long_pos] = s;
      long_pos = (long_pos + 1) % AVG_LEN;
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] stream_sample();
      if (run_left == 0) begin
         run_kind = run_kind_type'($urandom_range(0, 3));
         run_left = $urandom_range(1, 260);
         ramp_val = SAMPLE_W'($urandom);
      end
      run_left--;
      case (run_kind)
         RUN_NOISE: return SAMPLE_W'($urandom);
         RUN_LOUD:  return '1;
         RUN_QUIET: return SAMPLE_W'($urandom_range(0, 15));
         default: begin
            ramp_val += SAMPLE_W'(37);
            return ramp_val;
         end
      endcase
   endfunction

   function automatic void pick_idling();
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
   endfunction

   // result checker
   always @(posedge clock) begin
      meter_reading_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         rsp_taken = 1'b1;
         if (pending_readings.size() == 0) begin
            $error("unexpected result: peak %0d mean %0d level %0d",
                   rsp_window_peak, rsp_window_mean, rsp_mean_led_level);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_window_peak !== want.peak) begin
               $error("window_peak: expected %0d, got %0d", want.peak, rsp_window_peak);
               error_count++;
            end
            if (rsp_window_mean !== want.mean) begin
               $error("window_mean: expected %0d, got %0d", want.mean, rsp_window_mean);
               error_count++;
            end
            if (rsp_mean_led_level !== want.level) begin
               $error("mean_led_level: expected %0d, got %0d", want.level,
                      rsp_mean_led_level);
               error_count++;
            end
         end
      end
   end

   // receiver: a random wait after each item while rx_idle is set, plus long hold-offs on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            rx_gap = rx_idle ? $urandom_range(0, 11) : 0;
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      gap = tx_idle ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_readings.push_back(meter_predict(s));
   endtask

   // drop valid, let every result come back, then let the pipe settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      req_valid <= 1'b0;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_AVG_GAIN:   cfg_gain       = data[GAIN_W-1:0];
         CSR_FULL_SCALE: cfg_full_scale = data[FS_W-1:0];
         CSR_LED_COUNT:  cfg_leds       = data[LED_W-1:0];
         CSR_BASE_LEVEL: cfg_base       = data[LEVEL_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int gain, input int fs, input int leds, input int base);
      wait_idle();
      write_reg(CSR_AVG_GAIN, CSR_DATA_W'(gain));
      write_reg(CSR_FULL_SCALE, CSR_DATA_W'(fs));
      write_reg(CSR_LED_COUNT, CSR_DATA_W'(leds));
      write_reg(CSR_BASE_LEVEL, CSR_DATA_W'(base));
   endtask

   task automatic test_directed_samples();
      logic [SAMPLE_W-1:0] pattern [12];
      pattern = '{12'd0, 12'hFFF, 12'd1, 12'h800, 12'h7FF, 12'hAAA,
                  12'h555, 12'hFFF, 12'd0, 12'hFFE, 12'd2, 12'h001};
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      foreach (pattern[i]) send_sample(pattern[i]);
   endtask

   // base at its top pushes the level past 255
   task automatic test_level_saturation();
      apply_setting(1023, 1, 255, 255);
      repeat (4) send_sample(12'hFFF);
   endtask

   task automatic test_zero_full_scale();
      apply_setting(333, 0, 60, 0);
      send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'd100);
      send_sample(12'h800);
   endtask

   // upper data bits beyond each register's width must be dropped
   task automatic test_wide_register_values();
      wait_idle();
      write_reg(CSR_AVG_GAIN, 12'hFFF);
      write_reg(CSR_FULL_SCALE, 12'h0FF);
      write_reg(CSR_LED_COUNT, 12'hF3C);
      write_reg(CSR_BASE_LEVEL, 12'hF05);
      send_sample(12'hFFF);
      send_sample(12'h123);
      send_sample(12'd0);
      send_sample(12'hFFF);
   endtask

   task automatic test_config_sweep();
      int settings [8][4];
      settings = '{'{0, 1, 1, 0}, '{1023, 4095, 255, 255}, '{1023, 1, 255, 0},
                   '{333, 600, 60, 0}, '{1, 4095, 1, 0}, '{256, 2048, 128, 10},
                   '{0, 0, 0, 0}, '{0, 0, 0, 0}};
      for (int k = 6; k < 8; k++) begin
         settings[k][0] = $urandom_range(0, 1023);
         settings[k][1] = $urandom_range(1, 4095);
         settings[k][2] = $urandom_range(1, 255);
         settings[k][3] = $urandom_range(0, 255);
      end
      foreach (settings[k]) begin
         apply_setting(settings[k][0], settings[k][1], settings[k][2], settings[k][3]);
         pick_idling();
         repeat (100) send_sample(stream_sample());
      end
   endtask

   // stall the output long enough for the block to fill and stall its input
   task automatic test_backpressure();
      wait_idle();
      tx_idle = 1'b0;
      rx_idle = 1'b1;
      rx_hold = 300;
      repeat (80) send_sample(SAMPLE_W'($urandom));
   endtask

   task automatic test_sender_pause();
      pick_idling();
      repeat (30) send_sample(stream_sample());
      wait_idle();
      repeat (30) send_sample(stream_sample());
   endtask

   task automatic test_random_stream();
      apply_setting(1023, 4095, 255, 0);
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      // fill the long window with full-scale samples
      repeat (220) send_sample('1);
      for (int seg = 0; seg < 4; seg++) begin
         apply_setting($urandom_range(0, 1023), $urandom_range(0, 4095),
                       $urandom_range(1, 255), $urandom_range(0, 255));
         pick_idling();
         repeat (100) send_sample(stream_sample());
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_sample  = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_AVG_GAIN;
      csr_wdata   = '0;
      error_count = 0;
      cycle_count = 0;
      rx_hold     = 0;
      rx_gap      = 0;
      run_left    = 0;
      run_kind    = RUN_NOISE;
      ramp_val    = '0;
      tx_idle     = 1'b0;
      rx_idle     = 1'b0;
      rsp_taken   = 1'b0;
      meter_clear();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_samples();
      test_level_saturation();
      test_zero_full_scale();
      test_wide_register_values();
      test_config_sweep();
      test_backpressure();
      test_sender_pause();
      test_random_stream();

      wait_idle();
      if (error_count == 0)
         $display("window_peak_mean_level_meter_top_tb: clean");
      else
         $display("window_peak_mean_level_meter_top_tb: errors");
      $finish;
   end

endmodule

[filelist.f]
design/wpm_pkg.sv
design/wpm_peak_cell.sv
design/wpm_window.sv
design/wpm_rdiv.sv
design/wpm_div_cell.sv
design/window_peak_mean_level_meter_top.sv
design/wpm_checker.sv
bench/window_peak_mean_level_meter_top_tb.sv
